/* hdl/dag_longest_path_support_macros.svh */
// Assertion macros for the DAG longest-path block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef DAG_LONGEST_PATH_SUPPORT_MACROS_SVH
`define DAG_LONGEST_PATH_SUPPORT_MACROS_SVH
`ifndef SYNTHESIS
`define DLPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define DLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLPS_ASSERT_SAME(lbl, ante, cons, msg)
`define DLPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/dlps_pkg.sv */
// Shared constants for the DAG longest-path block.
// No dependencies.
package dlps_pkg;
    localparam int MAX_NODES = 64;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LEN_W = 7;
    localparam int ROW_W = MAX_NODES;
    localparam int CNT_W = 7;
    localparam int REG_NODE_COUNT = 0;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);
endpackage

/* hdl/dag_longest_path_support.sv */
// Top level of the DAG longest-path block: row store, relaxation sequencer, register port.
// Depends on dlps_pkg and dag_longest_path_support_macros.svh.
//
// Usage: each word on the s_ channel carries one adjacency row (tdata), the node it
// belongs to (tuser) and a last-row marker (tlast). A row word is stored when it is accepted.
// A word with tlast set also starts the computation over node_count nodes, clamped to 1..64.
// The computation makes n+1 passes over all n nodes; each node goes through row fetch,
// n successor reads through one memory port, drain and write-back, and a last row keeps
// the block busy, refusing new rows, until the result word is issued.
// A single result word then appears on the m_ channel: the longest path in nodes on
// tdata and the cycle flag on tuser; support is zero when a cycle is flagged.
// The result sits in an output register, so new rows are accepted while it waits.
// If a second result is ready before the first is taken, the block holds it and
// stays busy until the receiver takes the first one.
// node_count must be written via the register port only while idle (not enforced).
// Reset clears the sequencer and sets node_count to 64; stored rows are undefined
// until written, and path lengths need no clearing since the first pass reads zeros.
`include "dag_longest_path_support_macros.svh"

module dag_longest_path_support
    import dlps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ROW_W-1:0]     s_tdata,   // row_bits [63:0]
    input  logic [IDX_W-1:0]     s_tuser,   // row_index [5:0]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // support [6:0], zero pad [7]
    output logic                 m_tuser,   // cycle_found [0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROWRD,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   jd_reg, jd_next;
    logic               pvalid_reg, pvalid_next;
    logic [CNT_W-1:0]   pass_reg, pass_next;
    logic               cur_reg, cur_next;
    logic [LEN_W-1:0]   best_reg, best_next;
    logic [LEN_W-1:0]   own_reg, own_next;
    logic               changed_reg, changed_next;
    logic [LEN_W-1:0]   support_reg, support_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [LEN_W-1:0]   m_support_reg, m_support_next;
    logic               m_cycle_reg, m_cycle_next;
    logic [CNT_W-1:0]   node_count_reg;

    logic [ROW_W-1:0]   adj_mem [MAX_NODES];
    logic [LEN_W-1:0]   len_mem [2*MAX_NODES];
    logic [ROW_W-1:0]   adj_q;
    logic [LEN_W-1:0]   len_q;

    logic [CNT_W-1:0]   n_act;
    logic [IDX_W-1:0]   n_last;
    logic [LEN_W-1:0]   val;
    logic [LEN_W-1:0]   new_len;
    logic               in_acc;
    logic               cfg_wr;
    logic               last_node;
    logic               check_pass;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'(REG_NODE_COUNT));
    assign prdata   = (paddr[2] == 1'(REG_NODE_COUNT)) ? {25'd0, node_count_reg} : 32'd0;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_support_reg};
    assign m_tuser  = m_cycle_reg;

    always_comb begin
        if (node_count_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (node_count_reg > CNT_W'(MAX_NODES)) begin
            n_act = CNT_W'(MAX_NODES);
        end else begin
            n_act = node_count_reg;
        end
    end

    assign n_last     = IDX_W'(n_act - CNT_W'(1));
    assign val        = (pass_reg == '0) ? '0 : len_q;
    assign new_len    = best_reg + LEN_W'(1);
    assign last_node  = (i_reg == n_last);
    assign check_pass = (pass_reg == n_act);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
        end else if (cfg_wr) begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            adj_mem[s_tuser] <= s_tdata;
        end
        adj_q <= adj_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            len_mem[{~cur_reg, i_reg}] <= new_len;
        end
        len_q <= len_mem[{cur_reg, j_reg}];
    end

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pvalid_next    = 1'b0;
        pass_next      = pass_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        own_next       = own_reg;
        changed_next   = changed_reg;
        support_next   = support_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_support_next = m_support_reg;
        m_cycle_next   = m_cycle_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (pvalid_reg) begin
            if (adj_q[jd_reg] && (val > best_reg)) begin
                best_next = val;
            end
            if (jd_reg == i_reg) begin
                own_next = val;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tlast) begin
                    i_next       = '0;
                    pass_next    = '0;
                    cur_next     = 1'b0;
                    changed_next = 1'b0;
                    support_next = '0;
                    state_next   = ST_ROWRD;
                end
            end
            ST_ROWRD: begin
                best_next  = '0;
                own_next   = '0;
                j_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                pvalid_next = 1'b1;
                jd_next     = j_reg;
                if (j_reg == n_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (check_pass) begin
                    if (new_len != own_reg) begin
                        changed_next = 1'b1;
                    end
                    if (own_reg > support_reg) begin
                        support_next = own_reg;
                    end
                end
                if (last_node) begin
                    if (check_pass) begin
                        state_next = ST_DONE;
                    end else begin
                        pass_next  = pass_reg + CNT_W'(1);
                        cur_next   = ~cur_reg;
                        i_next     = '0;
                        state_next = ST_ROWRD;
                    end
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_ROWRD;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_support_next = changed_reg ? '0 : support_reg;
                    m_cycle_next   = changed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pvalid_reg   <= pvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        i_reg         <= i_next;
        j_reg         <= j_next;
        jd_reg        <= jd_next;
        pass_reg      <= pass_next;
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        own_reg       <= own_next;
        changed_reg   <= changed_next;
        support_reg   <= support_next;
        m_support_reg <= m_support_next;
        m_cycle_reg   <= m_cycle_next;
    end

    `DLPS_ASSERT_SAME(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg == ST_DONE), "result word appeared without a finished computation")
    `DLPS_ASSERT_SAME(a_cycle_zero_support, m_tvalid_reg && m_cycle_reg, m_support_reg == '0, "cycle flagged with nonzero support")
    `DLPS_ASSERT_SAME(a_support_nonzero, m_tvalid_reg && !m_cycle_reg, (m_support_reg != '0) && (m_support_reg <= n_act), "acyclic support outside node range")
    `DLPS_ASSERT_SAME(a_write_in_range, state_reg == ST_WRITE, (i_reg <= n_last) && (pass_reg <= n_act), "write-back beyond active nodes or passes")
    `DLPS_ASSERT_NEXT(a_scan_follows_fetch, state_reg == ST_ROWRD, (state_reg == ST_SCAN) && (j_reg == '0), "row fetch not followed by a scan from node zero")

endmodule
